// File: design/msv_pkg.sv
`timescale 1ns / 1ps

package msv_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_OUTPUT_RATE_HZ = 48000;
   localparam int DEFAULT_PHASE_BITS     = 32;
   localparam int DEFAULT_SINE_ADDR_BITS = 10;

   // Stream payload widths.
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   // Tuning: note n plus NOTE_OFFSET splits into octave and semitone; the step
   // is 440 Hz times the Q1.15 semitone ratio, shifted by octave and phase width.
   localparam int NOTE_COUNT      = 128;
   localparam int SEMITONES       = 12;
   localparam int NOTE_OFFSET     = 3;
   localparam int STEP_SHIFT_BASE = 21;
   localparam int TUNING_HZ       = 440;

   localparam logic [15:0] SEMITONE_Q15 [SEMITONES] = '{
      16'd32768, 16'd34716, 16'd36781, 16'd38968, 16'd41285, 16'd43740,
      16'd46341, 16'd49097, 16'd52016, 16'd55109, 16'd58386, 16'd61858
   };

   // Shared multiplier operand widths.
   localparam int MUL_A_BITS = 32;
   localparam int MUL_B_BITS = 33;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Q2.30 sine evaluation.
   localparam int          Q_FRAC      = 30;
   localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] Q30_HALF    = 32'h2000_0000;
   localparam logic [31:0] SINE_SCALE  = 32'd32767;
   localparam logic [14:0] SINE_MAX    = 15'h7FFF;

   // The series divides by 110, 72, 42, 20 and 6. Each division of a 32-bit
   // value is an exact multiply by ceil(2^s / d) followed by a right shift of s.
   localparam int TAYLOR_TERMS = 5;
   localparam logic [5:0] TAYLOR_SHIFT [TAYLOR_TERMS] = '{
      6'd39, 6'd39, 6'd38, 6'd37, 6'd35
   };
   localparam logic [32:0] TAYLOR_RECIP [TAYLOR_TERMS] = '{
      33'(((64'd1 << 39) + 64'd109) / 64'd110),
      33'(((64'd1 << 39) + 64'd71) / 64'd72),
      33'(((64'd1 << 38) + 64'd41) / 64'd42),
      33'(((64'd1 << 37) + 64'd19) / 64'd20),
      33'(((64'd1 << 35) + 64'd5) / 64'd6)
   };

   // Output scaling.
   localparam int          GAIN_FRAC  = 15;
   localparam logic [37:0] GAIN_ROUND = 38'd16384;
   localparam logic [22:0] SAMPLE_MAX = 23'h7F_FFFF;

   // Item kinds carried in tuser.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_MIDI = 1'b1;

   // MIDI status nibbles and controllers.
   localparam logic [3:0] MIDI_NOTE_OFF   = 4'h8;
   localparam logic [3:0] MIDI_NOTE_ON    = 4'h9;
   localparam logic [3:0] MIDI_CONTROLLER = 4'hB;
   localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

   // Sequencer steps of the sine and gain evaluation.
   localparam int          STEP_BITS   = 5;
   localparam logic [4:0] STEP_ANGLE    = 5'd0;
   localparam logic [4:0] STEP_SQUARE   = 5'd1;
   localparam logic [4:0] STEP_SERIES   = 5'd2;
   localparam logic [4:0] STEP_SINE     = 5'd12;
   localparam logic [4:0] STEP_ROUND    = 5'd13;
   localparam logic [4:0] STEP_VELOCITY = 5'd14;
   localparam logic [4:0] STEP_LEVEL    = 5'd15;
   localparam logic [4:0] STEP_FINAL    = 5'd16;

   localparam logic [15:0] LEVEL_RESET = 16'd4096;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

// File: design/midi_sine_voice.sv
`timescale 1ns / 1ps

// MIDI transaction: no response; the block stays ready and the next request is taken at once.
// Tick with the gate clear: the zero sample is valid on the cycle after acceptance.
// Tick with the gate set: one shared 32x33 multiplier runs 16 products and a final
// rounding step before the sample is valid; one item at a time.
// A tick holds the block until its sample is taken; the next request can be taken in the cycle after.
// Synchronous reset clears gate, phase, note and velocity and sets the level to 0.125.
module midi_sine_voice #(
   parameter int OUTPUT_RATE_HZ = msv_pkg::DEFAULT_OUTPUT_RATE_HZ,
   parameter int PHASE_BITS     = msv_pkg::DEFAULT_PHASE_BITS,
   parameter int SINE_ADDR_BITS = msv_pkg::DEFAULT_SINE_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Bits from 0: midi_status[7:0], midi_data_one[14:8], midi_data_two[21:15], zero.
   input  logic [msv_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // Bit 0: opcode.
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Bits from 0: sample_out[23:0], signed.
   output logic [msv_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [15:0]                        csr_wr_data
);
   import msv_pkg::*;

   localparam int IDX_LSB = PHASE_BITS - SINE_ADDR_BITS - 2;
   localparam logic [SINE_ADDR_BITS:0] QUARTER_LEN = {1'b1, {SINE_ADDR_BITS{1'b0}}};

   typedef logic [PHASE_BITS-1:0] step_table_type [NOTE_COUNT];

   function automatic step_table_type build_step_table();
      step_table_type tbl;
      logic [63:0]    num;
      logic [63:0]    scaled;
      int             v;
      int             shift_amt;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         v         = n + NOTE_OFFSET;
         shift_amt = PHASE_BITS - STEP_SHIFT_BASE + v / SEMITONES;
         num       = 64'(TUNING_HZ) * 64'(SEMITONE_Q15[v % SEMITONES]);
         scaled    = ((num << shift_amt) + 64'(OUTPUT_RATE_HZ / 2)) / 64'(OUTPUT_RATE_HZ);
         tbl[n]    = scaled[PHASE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam step_table_type STEP_TABLE = build_step_table();

   state_type                  state_ff, state_in;
   logic                       gate_ff, gate_in;
   logic [PHASE_BITS-1:0]      phase_ff, phase_in;
   logic [6:0]                 note_ff, note_in;
   logic [6:0]                 vel_ff, vel_in;
   logic [15:0]                level_ff, level_in;

   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic [2:0]                 div_ff, div_in;
   logic [SINE_ADDR_BITS:0]    idx_ff, idx_in;
   logic                       neg_ff, neg_in;
   logic [30:0]                t_ff, t_in;
   logic [31:0]                t2_ff, t2_in;
   logic [PROD_BITS-1:0]       prod_ff, prod_in;
   logic [RSP_DATA_BITS-1:0]   result_ff, result_in;

   logic [3:0]                 midi_kind;
   logic [6:0]                 midi_data_one;
   logic [6:0]                 midi_data_two;
   logic                       req_fire;
   logic [1:0]                 quadrant;
   logic [SINE_ADDR_BITS-1:0]  quarter_idx;

   logic [MUL_A_BITS-1:0]      mul_a;
   logic [MUL_B_BITS-1:0]      mul_b;
   logic [32:0]                quotient;
   logic [32:0]                y_next;
   logic [16:0]                sine_round;
   logic [14:0]                sine_mag;
   logic [23:0]                gain_round;
   logic [22:0]                sample_mag;

   assign midi_kind     = req_tdata[7:4];
   assign midi_data_one = req_tdata[14:8];
   assign midi_data_two = req_tdata[21:15];
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign rsp_tvalid    = (state_ff == ST_DONE);
   assign rsp_tdata     = result_ff;

   assign quadrant    = phase_ff[PHASE_BITS-1 -: 2];
   assign quarter_idx = phase_ff[IDX_LSB +: SINE_ADDR_BITS];

   // The series term y = 1 - (t2*y)/d; the division is the product just formed.
   assign quotient = 33'(prod_ff >> TAYLOR_SHIFT[div_ff]);
   assign y_next   = 33'(Q30_ONE) - quotient;

   assign sine_round = 17'((prod_ff + PROD_BITS'(Q30_HALF)) >> Q_FRAC);
   assign sine_mag   = (sine_round > 17'(SINE_MAX)) ? SINE_MAX : sine_round[14:0];

   assign gain_round = 24'((prod_ff[37:0] + GAIN_ROUND) >> GAIN_FRAC);
   assign sample_mag = (gain_round > 24'(SAMPLE_MAX)) ? SAMPLE_MAX : gain_round[22:0];

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_in = div_ff;
      case (step_ff)
         STEP_ANGLE: begin
            mul_a = HALF_PI_Q30;
            mul_b = MUL_B_BITS'(idx_ff);
         end
         STEP_SQUARE: begin
            mul_a = MUL_A_BITS'(prod_ff >> SINE_ADDR_BITS);
            mul_b = MUL_B_BITS'(prod_ff >> SINE_ADDR_BITS);
         end
         STEP_SERIES: begin
            mul_a = MUL_A_BITS'(prod_ff >> Q_FRAC);
            mul_b = MUL_B_BITS'(Q30_ONE);
         end
         STEP_SINE: begin
            mul_a = MUL_A_BITS'(t_ff);
            mul_b = y_next;
         end
         STEP_ROUND: begin
            mul_a = MUL_A_BITS'(prod_ff >> Q_FRAC);
            mul_b = MUL_B_BITS'(SINE_SCALE);
         end
         STEP_VELOCITY: begin
            mul_a = MUL_A_BITS'(sine_mag);
            mul_b = MUL_B_BITS'(vel_ff);
         end
         STEP_LEVEL: begin
            mul_a = MUL_A_BITS'(prod_ff[21:0]);
            mul_b = MUL_B_BITS'(level_ff);
         end
         STEP_FINAL: begin
            mul_a = '0;
            mul_b = '0;
         end
         default: begin
            // Odd steps divide t2*y by the next divisor; even steps form t2*y.
            if (step_ff[0]) begin
               mul_a = MUL_A_BITS'(prod_ff >> Q_FRAC);
               mul_b = TAYLOR_RECIP[div_ff];
            end else begin
               mul_a = t2_ff;
               mul_b = y_next;
               div_in = div_ff + 3'd1;
            end
         end
      endcase
   end

   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_comb begin
      state_in  = state_ff;
      gate_in   = gate_ff;
      phase_in  = phase_ff;
      note_in   = note_ff;
      vel_in    = vel_ff;
      level_in  = csr_wr_en ? csr_wr_data : level_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      neg_in    = neg_ff;
      t_in      = t_ff;
      t2_in     = t2_ff;
      result_in = result_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_MIDI) begin
                  if (midi_kind == MIDI_NOTE_ON) begin
                     gate_in = 1'b1;
                     note_in = midi_data_one;
                     vel_in  = midi_data_two;
                  end else if (midi_kind == MIDI_NOTE_OFF) begin
                     gate_in  = 1'b0;
                     phase_in = '0;
                  end else if (midi_kind == MIDI_CONTROLLER &&
                               (midi_data_one inside {CC_ALL_SOUND_OFF, CC_ALL_NOTES_OFF})) begin
                     gate_in  = 1'b0;
                     phase_in = '0;
                  end
               end else if (!gate_ff) begin
                  phase_in  = '0;
                  result_in = '0;
                  state_in  = ST_DONE;
               end else begin
                  // Sample the current phase, then advance it for the next tick.
                  idx_in   = quadrant[0] ? (QUARTER_LEN - {1'b0, quarter_idx})
                                         : {1'b0, quarter_idx};
                  neg_in   = quadrant[1];
                  phase_in = phase_ff + STEP_TABLE[note_ff];
                  step_in  = STEP_ANGLE;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            step_in = step_ff + 5'd1;
            if (step_ff == STEP_SQUARE) begin
               t_in = 31'(prod_ff >> SINE_ADDR_BITS);
            end
            if (step_ff == STEP_SERIES) begin
               t2_in = 32'(prod_ff >> Q_FRAC);
            end
            if (step_ff == STEP_FINAL) begin
               result_in = neg_ff ? 24'(24'd0 - {1'b0, sample_mag}) : {1'b0, sample_mag};
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         gate_ff  <= 1'b0;
         phase_ff <= '0;
         note_ff  <= '0;
         vel_ff   <= '0;
         level_ff <= LEVEL_RESET;
      end else begin
         state_ff <= state_in;
         gate_ff  <= gate_in;
         phase_ff <= phase_in;
         note_ff  <= note_in;
         vel_ff   <= vel_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      div_ff    <= req_fire ? 3'd0 : div_in;
      idx_ff    <= idx_in;
      neg_ff    <= neg_in;
      t_ff      <= t_in;
      t2_ff     <= t2_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

endmodule
